// ===== rtl/hpse_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// hpse_pkg: shared types and codes for the parameter set extractor
// Parse phase codes, end status codes and the result record.
// ----------------------------------------------------------------------------
package hpse_pkg;

  // Parse phases
  localparam logic [2:0] PH_HEADER  = 3'd0;
  localparam logic [2:0] PH_ARR_HDR = 3'd1;
  localparam logic [2:0] PH_CNT_HI  = 3'd2;
  localparam logic [2:0] PH_CNT_LO  = 3'd3;
  localparam logic [2:0] PH_LEN_HI  = 3'd4;
  localparam logic [2:0] PH_LEN_LO  = 3'd5;
  localparam logic [2:0] PH_PAYLOAD = 3'd6;
  localparam logic [2:0] PH_DONE    = 3'd7;

  // End status codes
  localparam logic [1:0] ST_FOUND  = 2'd0;
  localparam logic [1:0] ST_SHORT  = 2'd1;
  localparam logic [1:0] ST_BEYOND = 2'd2;
  localparam logic [1:0] ST_TRUNC  = 2'd3;

  // Result kinds
  localparam logic KIND_BYTE   = 1'b0;
  localparam logic KIND_STATUS = 1'b1;

  // Position of the array count in the fixed header
  localparam logic [4:0] COUNT_POS = 5'd22;

  // One result record
  typedef struct packed {
    logic       kind;
    logic [7:0] payload_byte;
    logic [1:0] status;
    logic       last_of_item;
  } result_t;

endpackage : hpse_pkg
`default_nettype wire

// ===== rtl/hevc_parameter_set_extractor.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// hevc_parameter_set_extractor: pull one NAL out of a decoder config record
// Parses the record byte by byte and streams the payload of the selected
// parameter set NAL, followed by one end status per record.
// ----------------------------------------------------------------------------
//  channel | handshake            | payload
//  --------+----------------------+-----------------------------------------
//  in      | in_valid / in_stall  | record_byte, end_of_record
//  out     | out_valid / out_stall| kind, payload_byte, status, last_of_item
//  cfg     | cfg_valid / cfg_ready| cfg_data (wanted_index)
//
//  One input byte is parsed in the cycle it is transferred; its results
//  (none, one or two) go into a four-entry result queue and leave one per
//  cycle while out_stall is low. A byte a cycle is sustained unless
//  in_stall is high; the queue absorbs two-result bytes (last selected byte).
//  in_stall rises when the queue has fewer than two free entries.
//  Synchronous reset clears the parser, the queue and wanted_index.
// ----------------------------------------------------------------------------
module hevc_parameter_set_extractor (
  input  wire logic                 clk,
  input  wire logic                 rst,
  // input bytes
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire logic [7:0]           record_byte,
  input  wire logic                 end_of_record,
  // results
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output logic                      kind,
  output logic [7:0]                payload_byte,
  output logic [1:0]                status,
  output logic                      last_of_item,
  // configuration
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [15:0]          cfg_data
);
  import hpse_pkg::*;

  // Configuration register
  logic [15:0] wanted_index;

  // Parser state
  logic [2:0]  parse_phase,     parse_phase_next;
  logic [4:0]  header_position, header_position_next;
  logic [7:0]  arrays_left,     arrays_left_next;
  logic [15:0] nals_left,       nals_left_next;
  logic [15:0] payload_left,    payload_left_next;
  logic [7:0]  high_byte_hold,  high_byte_hold_next;
  logic [15:0] nal_counter,     nal_counter_next;
  logic        selected_active, selected_active_next;

  // Results of the current byte
  logic        res_cnt0, res_cnt1;  // result slot 0 / 1 used
  result_t     res0, res1;

  // Result queue
  result_t     queue [4];
  logic [1:0]  wr_ptr, rd_ptr;
  logic [2:0]  count;
  logic [1:0]  pushed;

  logic in_xfer, out_xfer;
  logic [15:0] combined;

  assign cfg_ready = 1'b1;
  assign in_stall  = (count > 3'd2);
  assign in_xfer   = in_valid && !in_stall;
  assign out_valid = (count != 3'd0);
  assign out_xfer  = out_valid && !out_stall;
  assign combined  = {high_byte_hold, record_byte};
  assign pushed    = in_xfer ? ({1'b0, res_cnt0} + {1'b0, res_cnt1}) : 2'd0;

  // Configuration write
  always_ff @(posedge clk) begin
    if (rst) begin
      wanted_index <= '0;
    end else if (cfg_valid && cfg_ready) begin
      wanted_index <= cfg_data;
    end
  end

  // Parse one byte
  always_comb begin
    logic [15:0] nals_dec;
    logic [7:0]  arrays_dec;
    logic        nal_end;      // nal_done path taken
    logic        arr_end;      // array_done path taken
    logic        decide_valid;
    logic [1:0]  decide_status;
    logic        emit_byte;

    parse_phase_next     = parse_phase;
    header_position_next = header_position;
    arrays_left_next     = arrays_left;
    nals_left_next       = nals_left;
    payload_left_next    = payload_left;
    high_byte_hold_next  = high_byte_hold;
    nal_counter_next     = nal_counter;
    selected_active_next = selected_active;

    nal_end       = 1'b0;
    arr_end       = 1'b0;
    decide_valid  = 1'b0;
    decide_status = ST_FOUND;
    emit_byte     = 1'b0;

    case (parse_phase)
      PH_HEADER: begin
        if (header_position >= COUNT_POS) begin
          arrays_left_next = record_byte;
          if (record_byte == 8'd0) begin
            decide_valid  = 1'b1;
            decide_status = ST_BEYOND;
          end else begin
            parse_phase_next = PH_ARR_HDR;
          end
        end else begin
          header_position_next = header_position + 5'd1;
        end
      end
      PH_ARR_HDR: parse_phase_next = PH_CNT_HI;
      PH_CNT_HI: begin
        high_byte_hold_next = record_byte;
        parse_phase_next    = PH_CNT_LO;
      end
      PH_CNT_LO: begin
        nals_left_next = combined;
        if (combined == 16'd0) arr_end = 1'b1;
        else                   parse_phase_next = PH_LEN_HI;
      end
      PH_LEN_HI: begin
        high_byte_hold_next = record_byte;
        parse_phase_next    = PH_LEN_LO;
      end
      PH_LEN_LO: begin
        payload_left_next    = combined;
        selected_active_next = (nal_counter == wanted_index);
        if (combined != 16'd0) begin
          parse_phase_next = PH_PAYLOAD;
        end else if (nal_counter == wanted_index) begin
          decide_valid  = 1'b1;
          decide_status = ST_FOUND;
        end else begin
          nal_end = 1'b1;
        end
      end
      PH_PAYLOAD: begin
        emit_byte         = selected_active;
        payload_left_next = payload_left - 16'd1;
        if (payload_left == 16'd1) begin
          if (selected_active) begin
            decide_valid  = 1'b1;
            decide_status = ST_FOUND;
          end else begin
            nal_end = 1'b1;
          end
        end
      end
      default: ;
    endcase

    // Finished NAL: count it and step through the array
    nals_dec = nals_left - 16'd1;
    if (nal_end) begin
      if (nal_counter != 16'hFFFF) nal_counter_next = nal_counter + 16'd1;
      nals_left_next = nals_dec;
      if (nals_dec == 16'd0) arr_end = 1'b1;
      else                   parse_phase_next = PH_LEN_HI;
    end

    // Finished array
    arrays_dec = arrays_left - 8'd1;
    if (arr_end) begin
      arrays_left_next = arrays_dec;
      if (arrays_dec == 8'd0) begin
        decide_valid  = 1'b1;
        decide_status = ST_BEYOND;
      end else begin
        parse_phase_next = PH_ARR_HDR;
      end
    end

    if (decide_valid) parse_phase_next = PH_DONE;

    // Assemble results: byte first, then a status
    res0     = '0;
    res1     = '0;
    res_cnt0 = 1'b0;
    res_cnt1 = 1'b0;
    if (emit_byte) begin
      res_cnt0          = 1'b1;
      res0.kind         = KIND_BYTE;
      res0.payload_byte = record_byte;
    end
    if (decide_valid || (end_of_record && parse_phase_next != PH_DONE)) begin
      if (!decide_valid) begin
        decide_status = (parse_phase_next == PH_HEADER) ? ST_SHORT : ST_TRUNC;
      end
      if (emit_byte) begin
        res_cnt1    = 1'b1;
        res1.kind   = KIND_STATUS;
        res1.status = decide_status;
      end else begin
        res_cnt0    = 1'b1;
        res0.kind   = KIND_STATUS;
        res0.status = decide_status;
      end
    end
    res0.last_of_item = res_cnt0 && !res_cnt1;
    res1.last_of_item = res_cnt1;

    // End of record clears the parser
    if (end_of_record) begin
      parse_phase_next     = PH_HEADER;
      header_position_next = '0;
      arrays_left_next     = '0;
      nals_left_next       = '0;
      payload_left_next    = '0;
      high_byte_hold_next  = '0;
      nal_counter_next     = '0;
      selected_active_next = 1'b0;
    end
  end

  // Parser registers
  always_ff @(posedge clk) begin
    if (rst) begin
      parse_phase     <= PH_HEADER;
      header_position <= '0;
      arrays_left     <= '0;
      nals_left       <= '0;
      payload_left    <= '0;
      high_byte_hold  <= '0;
      nal_counter     <= '0;
      selected_active <= 1'b0;
    end else if (in_xfer) begin
      parse_phase     <= parse_phase_next;
      header_position <= header_position_next;
      arrays_left     <= arrays_left_next;
      nals_left       <= nals_left_next;
      payload_left    <= payload_left_next;
      high_byte_hold  <= high_byte_hold_next;
      nal_counter     <= nal_counter_next;
      selected_active <= selected_active_next;
    end
  end

  // Result queue storage
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      if (res_cnt0) queue[wr_ptr] <= res0;
      if (res_cnt1) queue[wr_ptr + 2'd1] <= res1;
    end
  end

  // Result queue pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + pushed;
      if (out_xfer) rd_ptr <= rd_ptr + 2'd1;
      count <= count + {1'b0, pushed} - {2'b00, out_xfer};
    end
  end

  // Queue head drives the result ports
  assign kind         = queue[rd_ptr].kind;
  assign payload_byte = queue[rd_ptr].payload_byte;
  assign status       = queue[rd_ptr].status;
  assign last_of_item = queue[rd_ptr].last_of_item;

endmodule : hevc_parameter_set_extractor
`default_nettype wire
